FILE: rtl/scrc_pkg.sv
// Package for the segment/rectangle clip test: configuration width and the
// side-band flags that ride beside the quotient pipeline. No dependencies.
package scrc_pkg;

  // Width of the item ports and of the epsilon register
  localparam int IN_W  = 32;
  localparam int EPS_W = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(7);

  // Per-item flags carried alongside the four quotients
  typedef struct packed {
    logic valid;
    logic par_x;   // x component below epsilon
    logic in_x;    // start x inside the x range
    logic dneg_x;  // x component negative
    logic neg_x0;  // sign of quotient for x_min
    logic neg_x1;  // sign of quotient for x_max
    logic par_y;
    logic in_y;
    logic dneg_y;
    logic neg_y0;
    logic neg_y1;
  } side_t;

endpackage

FILE: rtl/segment_rectangle_clip_test_core.sv
// Top level of the segment/rectangle slab test: front end, four pipelined
// dividers (scrc_div) and the window logic. Uses scrc_pkg.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   request | in_valid, in_stall, start_x..    | in
//   result  | out_valid, out_stall, hits       | out
//   config  | cfg_wr_en, cfg_wr_data           | in
//
// One request enters per cycle while in_stall is low; the dividers form a
// one-bit-per-stage quotient pipeline.
// rst clears valid bits and loads parallel_epsilon with 7.
// A stalled result freezes the whole pipeline; in_stall rises in the same
// cycle, so nothing is lost or repeated.
module segment_rectangle_clip_test_core
  import scrc_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [EPS_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IN_W-1:0]  start_x,
  input  logic [IN_W-1:0]  start_y,
  input  logic [IN_W-1:0]  dir_x,
  input  logic [IN_W-1:0]  dir_y,
  input  logic [IN_W-1:0]  rect_x_min,
  input  logic [IN_W-1:0]  rect_x_max,
  input  logic [IN_W-1:0]  rect_y_min,
  input  logic [IN_W-1:0]  rect_y_max,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             hits
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int TW = CW + 2;
  localparam int DL = CW + 1;
  localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] LIM_NEG = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [TW-1:0] T_INF = {2'b01, {CW{1'b0}}};
  localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< FRAC_BITS;

  logic             adv;
  logic [EPS_W-1:0] parallel_epsilon;

  // Advance everything unless the result register is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_epsilon <= EPS_RESET;
    end else if (cfg_wr_en) begin
      parallel_epsilon <= cfg_wr_data;
    end
  end

  // Stage 1: capture coordinates at working width
  logic                 v1;
  logic signed [CW-1:0] px, py, dx, dy, x0, x1, y0, y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px <= CW'($signed(start_x));
      py <= CW'($signed(start_y));
      dx <= CW'($signed(dir_x));
      dy <= CW'($signed(dir_y));
      x0 <= CW'($signed(rect_x_min));
      x1 <= CW'($signed(rect_x_max));
      y0 <= CW'($signed(rect_y_min));
      y1 <= CW'($signed(rect_y_max));
    end
  end

  // Stage 2: differences, direction magnitudes, parallel and inside flags
  logic                 v2;
  logic signed [DW-1:0] dfx0, dfx1, dfy0, dfy1;
  logic [CW-1:0]        dmx, dmy;
  logic                 pax2, inx2, dnx2, pay2, iny2, dny2;
  logic [CW-1:0]        dmx_c, dmy_c;

  assign dmx_c = dx[CW-1] ? CW'(-dx) : CW'(dx);
  assign dmy_c = dy[CW-1] ? CW'(-dy) : CW'(dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dfx0 <= DW'(x0) - DW'(px);
      dfx1 <= DW'(x1) - DW'(px);
      dfy0 <= DW'(y0) - DW'(py);
      dfy1 <= DW'(y1) - DW'(py);
      dmx  <= dmx_c;
      dmy  <= dmy_c;
      pax2 <= (dx == '0) || (dmx_c < CW'(parallel_epsilon));
      pay2 <= (dy == '0) || (dmy_c < CW'(parallel_epsilon));
      inx2 <= !(px < x0 || px > x1);
      iny2 <= !(py < y0 || py > y1);
      dnx2 <= dx[CW-1];
      dny2 <= dy[CW-1];
    end
  end

  // Stage 3: dividend magnitudes and quotient signs
  logic [DW-1:0] nx0, nx1, ny0, ny1;
  logic [CW-1:0] dmx3, dmy3;
  side_t         sd [0:DL];

  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0].valid <= 1'b0;
    end else if (adv) begin
      sd[0].valid <= v2;
    end
    if (adv) begin
      nx0  <= dfx0[DW-1] ? DW'(-dfx0) : DW'(dfx0);
      nx1  <= dfx1[DW-1] ? DW'(-dfx1) : DW'(dfx1);
      ny0  <= dfy0[DW-1] ? DW'(-dfy0) : DW'(dfy0);
      ny1  <= dfy1[DW-1] ? DW'(-dfy1) : DW'(dfy1);
      dmx3 <= dmx;
      dmy3 <= dmy;
      sd[0].par_x  <= pax2;
      sd[0].in_x   <= inx2;
      sd[0].dneg_x <= dnx2;
      sd[0].neg_x0 <= dfx0[DW-1] ^ dnx2;
      sd[0].neg_x1 <= dfx1[DW-1] ^ dnx2;
      sd[0].par_y  <= pay2;
      sd[0].in_y   <= iny2;
      sd[0].dneg_y <= dny2;
      sd[0].neg_y0 <= dfy0[DW-1] ^ dny2;
      sd[0].neg_y1 <= dfy1[DW-1] ^ dny2;
    end
  end

  // Dividers: one per bound
  logic [CW-1:0] qx0, qx1, qy0, qy1;
  logic          ox0, ox1, oy0, oy1;

  scrc_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_x0 (
    .clk(clk), .en(adv), .n(nx0), .d(dmx3), .q(qx0), .ovf(ox0));
  scrc_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_x1 (
    .clk(clk), .en(adv), .n(nx1), .d(dmx3), .q(qx1), .ovf(ox1));
  scrc_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_y0 (
    .clk(clk), .en(adv), .n(ny0), .d(dmy3), .q(qy0), .ovf(oy0));
  scrc_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_y1 (
    .clk(clk), .en(adv), .n(ny1), .d(dmy3), .q(qy1), .ovf(oy1));

  // Delay side flags to match divider latency
  for (genvar k = 0; k < DL; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k+1].valid <= 1'b0;
      end else if (adv) begin
        sd[k+1].valid <= sd[k].valid;
      end
      if (adv) begin
        sd[k+1].par_x  <= sd[k].par_x;
        sd[k+1].in_x   <= sd[k].in_x;
        sd[k+1].dneg_x <= sd[k].dneg_x;
        sd[k+1].neg_x0 <= sd[k].neg_x0;
        sd[k+1].neg_x1 <= sd[k].neg_x1;
        sd[k+1].par_y  <= sd[k].par_y;
        sd[k+1].in_y   <= sd[k].in_y;
        sd[k+1].dneg_y <= sd[k].dneg_y;
        sd[k+1].neg_y0 <= sd[k].neg_y0;
        sd[k+1].neg_y1 <= sd[k].neg_y1;
      end
    end
  end

  // Saturate a quotient magnitude and apply its sign
  function automatic logic signed [DW-1:0] sat_t(input logic [CW-1:0] q,
                                                 input logic ovf,
                                                 input logic neg);
    logic [CW-1:0] lim;
    logic [CW-1:0] full;
    lim  = neg ? LIM_NEG : LIM_POS;
    full = (ovf || q > lim) ? lim : q;
    return neg ? -$signed({1'b0, full}) : $signed({1'b0, full});
  endfunction

  // Stage 4: signed, saturated parameters
  side_t                s4;
  logic signed [DW-1:0] tx0, tx1, ty0, ty1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid <= 1'b0;
    end else if (adv) begin
      s4.valid <= sd[DL].valid;
    end
    if (adv) begin
      s4.par_x  <= sd[DL].par_x;
      s4.in_x   <= sd[DL].in_x;
      s4.dneg_x <= sd[DL].dneg_x;
      s4.neg_x0 <= sd[DL].neg_x0;
      s4.neg_x1 <= sd[DL].neg_x1;
      s4.par_y  <= sd[DL].par_y;
      s4.in_y   <= sd[DL].in_y;
      s4.dneg_y <= sd[DL].dneg_y;
      s4.neg_y0 <= sd[DL].neg_y0;
      s4.neg_y1 <= sd[DL].neg_y1;
      tx0 <= sat_t(qx0, ox0, sd[DL].neg_x0);
      tx1 <= sat_t(qx1, ox1, sd[DL].neg_x1);
      ty0 <= sat_t(qy0, oy0, sd[DL].neg_y0);
      ty1 <= sat_t(qy1, oy1, sd[DL].neg_y1);
    end
  end

  // Stage 5: pick entry and exit per axis
  logic                 v5, pax5, inx5, pay5, iny5;
  logic signed [TW-1:0] tnx, tfx, tny, tfy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= s4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pax5 <= s4.par_x;
      inx5 <= s4.in_x;
      pay5 <= s4.par_y;
      iny5 <= s4.in_y;
      tnx  <= TW'(s4.dneg_x ? tx1 : tx0);
      tfx  <= TW'(s4.dneg_x ? tx0 : tx1);
      tny  <= TW'(s4.dneg_y ? ty1 : ty0);
      tfy  <= TW'(s4.dneg_y ? ty0 : ty1);
    end
  end

  // Stage 6: window after the x slab
  logic                 v6, okx6, pay6, iny6;
  logic signed [TW-1:0] wmin6, wmax6, tny6, tfy6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pay6 <= pay5;
      iny6 <= iny5;
      tny6 <= tny;
      tfy6 <= tfy;
      if (pax5) begin
        wmin6 <= -T_INF;
        wmax6 <= T_INF;
        okx6  <= inx5;
      end else begin
        wmin6 <= tnx;
        wmax6 <= tfx;
        okx6  <= !(tnx > tfx);
      end
    end
  end

  // Stage 7: narrow the window by the y slab
  logic                 v7, okx7, pay7, iny7;
  logic signed [TW-1:0] wmin7, wmax7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      okx7 <= okx6;
      pay7 <= pay6;
      iny7 <= iny6;
      if (pay6) begin
        wmin7 <= wmin6;
        wmax7 <= wmax6;
      end else begin
        wmin7 <= (tny6 > wmin6) ? tny6 : wmin6;
        wmax7 <= (tfy6 < wmax6) ? tfy6 : wmax6;
      end
    end
  end

  // Stage 8: final checks into the result register
  logic hit_next;

  assign hit_next = okx7 && (pay7 ? iny7 : !(wmin7 > wmax7))
                    && !(wmax7 < 0) && !(wmin7 > T_ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hits <= hit_next;
    end
  end

endmodule

FILE: rtl/scrc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Computes (n << FRAC_BITS) / d with an overflow flag; no package needed.
module scrc_div #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [COORD_WIDTH:0]   n,
  input  logic [COORD_WIDTH-1:0] d,
  output logic [COORD_WIDTH-1:0] q,
  output logic                   ovf
);

  localparam int CW = COORD_WIDTH;
  localparam int NW = CW + 1 + FRAC_BITS;

  logic [NW-1:0] num;
  logic [CW-1:0] rem  [0:CW];
  logic [CW-1:0] low  [0:CW];
  logic [CW-1:0] quo  [0:CW];
  logic [CW-1:0] dd   [0:CW];
  logic          of   [0:CW];

  // Scale the dividend; a high part at or above d overflows the quotient
  assign num = {n, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= CW'(num >> CW);
      low[0] <= num[CW-1:0];
      quo[0] <= '0;
      dd[0]  <= d;
      of[0]  <= (num >> CW) >= NW'(d);
    end
  end

  // One trial subtract per stage
  for (genvar k = 0; k < CW; k++) begin : g_step
    logic [CW:0] trial;
    logic        ge;

    assign trial = {rem[k], low[k][CW-1]};
    assign ge    = trial >= {1'b0, dd[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? CW'(trial - {1'b0, dd[k]}) : CW'(trial);
        low[k+1] <= {low[k][CW-2:0], 1'b0};
        quo[k+1] <= {quo[k][CW-2:0], ge};
        dd[k+1]  <= dd[k];
        of[k+1]  <= of[k];
      end
    end
  end

  assign q   = quo[CW];
  assign ovf = of[CW];

endmodule

FILE: bench/segment_rectangle_clip_test_core_tb.sv
// Testbench for segment_rectangle_clip_test_core: random and directed slab tests
// checked against a behavioral predictor of the hit bit. Depends on scrc_pkg.
module segment_rectangle_clip_test_core_tb;
  import scrc_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int LAT = CW + 9;

  typedef struct {
    logic [IN_W-1:0] sx, sy, dx, dy, x0, x1, y0, y1;
  } seg_req_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [EPS_W-1:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [IN_W-1:0] start_x = '0, start_y = '0, dir_x = '0, dir_y = '0;
  logic [IN_W-1:0] rect_x_min = '0, rect_x_max = '0, rect_y_min = '0, rect_y_max = '0;
  logic out_valid;
  logic out_stall = 0;
  logic hits;

  seg_req_t pending_q[$];
  bit hit_q[$];
  logic [EPS_W-1:0] eps_model = EPS_RESET;
  int mismatches = 0;
  bit sender_hold = 0;
  bit calm = 0;

  segment_rectangle_clip_test_core u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .dir_x(dir_x), .dir_y(dir_y),
    .rect_x_min(rect_x_min), .rect_x_max(rect_x_max),
    .rect_y_min(rect_y_min), .rect_y_max(rect_y_max),
    .out_valid(out_valid), .out_stall(out_stall), .hits(hits)
  );

  always #6 clk = ~clk;

  // Saturated fixed-point quotient of the slab parameter
  function automatic longint slab_param(longint num, longint den);
    longint unsigned n, d, q, r, frac, full, lim;
    bit neg;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    neg = (num < 0) != (den < 0);
    lim = neg ? (64'd1 << (CW - 1)) : (64'd1 << (CW - 1)) - 1;
    if (n == 0) return 0;
    q = n / d;
    r = n % d;
    frac = 0;
    if (q > (lim >> FB)) full = lim;
    else begin
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= d) begin
          r = r - d;
          frac = frac | 1;
        end
      end
      full = (q << FB) | frac;
      if (full > lim) full = lim;
    end
    return neg ? -longint'(full) : longint'(full);
  endfunction

  // Narrow the window by one axis; return 0 on rejection
  function automatic bit narrow_axis(longint p, longint d, longint lo, longint hi,
                                     inout longint tmin, inout longint tmax);
    longint t0, t1, dm;
    dm = d < 0 ? -d : d;
    if (d == 0 || dm < longint'(eps_model)) return !(p < lo || p > hi);
    t0 = slab_param(lo - p, d);
    t1 = slab_param(hi - p, d);
    if (d < 0) begin
      if (t1 > tmin) tmin = t1;
      if (t0 < tmax) tmax = t0;
    end else begin
      if (t0 > tmin) tmin = t0;
      if (t1 < tmax) tmax = t1;
    end
    return !(tmin > tmax);
  endfunction

  function automatic bit predict_hit(seg_req_t r);
    longint tmin, tmax;
    bit h;
    tmin = -(longint'(1) << CW);
    tmax = longint'(1) << CW;
    h = narrow_axis(longint'($signed(r.sx)), longint'($signed(r.dx)),
                    longint'($signed(r.x0)), longint'($signed(r.x1)), tmin, tmax);
    if (h)
      h = narrow_axis(longint'($signed(r.sy)), longint'($signed(r.dy)),
                      longint'($signed(r.y0)), longint'($signed(r.y1)), tmin, tmax);
    if (h && tmax < 0) h = 0;
    if (h && tmin > (longint'(1) << FB)) h = 0;
    return h;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic seg_req_t rand_req();
    seg_req_t r;
    logic [31:0] a, b;
    r.sx = rand_coord(); r.sy = rand_coord();
    r.dx = rand_coord(); r.dy = rand_coord();
    a = rand_coord(); b = rand_coord();
    // mostly well-formed rectangles, sometimes inverted
    if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
      r.x0 = b; r.x1 = a;
    end else begin
      r.x0 = a; r.x1 = b;
    end
    a = rand_coord(); b = rand_coord();
    if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
      r.y0 = b; r.y1 = a;
    end else begin
      r.y0 = a; r.y1 = b;
    end
    return r;
  endfunction

  function automatic seg_req_t mk(logic [31:0] sx, sy, dx, dy, x0, x1, y0, y1);
    seg_req_t r;
    r.sx = sx; r.sy = sy; r.dx = dx; r.dy = dy;
    r.x0 = x0; r.x1 = x1; r.y0 = y0; r.y1 = y1;
    return r;
  endfunction

  // Driver: present the next request, hold it while stalled
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && !sender_hold && (calm || $urandom_range(0, 99) >= 29)) begin
          seg_req_t r;
          r = pending_q.pop_front();
          hit_q.push_back(predict_hit(r));
          in_valid <= 1;
          start_x <= r.sx; start_y <= r.sy; dir_x <= r.dx; dir_y <= r.dy;
          rect_x_min <= r.x0; rect_x_max <= r.x1;
          rect_y_min <= r.y0; rect_y_max <= r.y1;
        end else in_valid <= 0;
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 29);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (hit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hits=%0b", hits);
      end else begin
        bit exp_hit;
        exp_hit = hit_q.pop_front();
        if (hits !== exp_hit) begin
          mismatches++;
          if (mismatches <= 10) $display("hits mismatch: expected %0b got %0b", exp_hit, hits);
        end
      end
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || hit_q.size() > 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_eps(logic [EPS_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    eps_model = v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    // directed: extremes, parallel axes, inverted box, window ends
    pending_q.push_back(mk(0, 0, 32'h10000, 32'h10000, 32'h8000, 32'h18000, 32'h8000, 32'h18000));
    pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(0, 0, 0, 0, 1, 2, 0, 0));
    pending_q.push_back(mk(5, 5, 3, 32'hfffffffd, 0, 10, 0, 10));
    pending_q.push_back(mk(0, 0, 32'h10000, 0, 32'h20000, 32'h30000, 0, 0));
    pending_q.push_back(mk(0, 0, 32'h10000, 0, 32'h10000, 32'h30000, 0, 0));
    pending_q.push_back(mk(0, 0, 32'hffff0000, 0, 32'hfffe0000, 32'hffff8000, 0, 0));
    pending_q.push_back(mk(0, 0, 32'h10000, 0, 32'hfffe0000, 32'hffff0000, 0, 0));
    pending_q.push_back(mk(0, 0, 32'h10000, 32'h10000, 32'h30000, 32'h10000, 0, 32'h10000));
    pending_q.push_back(mk(32'h80000000, 32'h7fffffff, 1, 32'hffffffff,
                           32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    pending_q.push_back(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                           32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    pending_q.push_back(mk(32'h80000000, 0, 32'h7fffffff, 8, 32'h7fffffff,
                           32'h7fffffff, 32'hfffffff0, 32'h10));
    pending_q.push_back(mk(0, 0, 6, 7, 32'hffffffff, 1, 32'hffffffff, 1));
    pending_q.push_back(mk(0, 0, 32'hfffffffa, 32'hfffffff9, 32'h10, 32'h20, 32'h10, 32'h20));
    pending_q.push_back(mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                           32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
    drain();
    // random phases across epsilon settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_eps(16'h0000);
        1: write_eps(16'hffff);
        2: write_eps(16'($urandom()));
        3: write_eps(EPS_RESET);
        default: write_eps(16'h0001);
      endcase
      calm = (ph == 2);
      for (int i = 0; i < 110; i++) pending_q.push_back(rand_req());
      if (ph == 3) begin
        // let every result come back before resuming
        while (pending_q.size() > 55) @(posedge clk);
        sender_hold = 1;
        while (in_valid || hit_q.size() > 0) @(posedge clk);
        sender_hold = 0;
      end
      drain();
    end
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: segment_rectangle_clip_test_core.f
rtl/scrc_pkg.sv
rtl/scrc_div.sv
rtl/segment_rectangle_clip_test_core.sv
bench/segment_rectangle_clip_test_core_tb.sv
